FILE: hw/rtl/cdp_pkg.sv
// ============================================================================
// cdp_pkg: shared types and constants of the coin change dispenser
// Word formats, operation and status codes, denomination tables and the
// control and token structs that pass between the controller and the cells.
// ============================================================================
`default_nettype none

package cdp_pkg;

  localparam int NUM_DENOMS = 8;
  localparam int SLOT_W     = $clog2(NUM_DENOMS);
  localparam int COUNT_W    = 10;
  localparam int AMOUNT_W   = 16;
  localparam int VALUE_W    = 10;
  localparam int RECIP_W    = 32;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_CHANGE = 2'd1;
  localparam logic [OP_W-1:0] OP_REFILL = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_EXACT = 2'd2;

  localparam logic [COUNT_W-1:0] DEFAULT_COUNT_RST = 10'd20;

  // Face value of each slot in cents, smallest first.
  localparam logic [VALUE_W-1:0] FACE_TAB [NUM_DENOMS] = '{
    10'd5, 10'd10, 10'd20, 10'd50, 10'd100, 10'd200, 10'd500, 10'd1000
  };

  // Rounded-up reciprocals, ceil(2^32 / face). For any 16-bit amount the top
  // bits of amount * reciprocal give the exact quotient amount / face.
  localparam logic [RECIP_W-1:0] RECIP_TAB [NUM_DENOMS] = '{
    32'd858993460, 32'd429496730, 32'd214748365, 32'd85899346,
    32'd42949673,  32'd21474837,  32'd8589935,   32'd4294968
  };

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  count_value;
    logic [AMOUNT_W-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   coin_slot;
    logic [VALUE_W-1:0]  face_cents;
    logic [COUNT_W-1:0]  dispensed;
    logic                last;
  } out_word_t;

  // Commands broadcast from the controller to every cell.
  typedef struct packed {
    logic               load_we;
    logic [SLOT_W-1:0]  load_slot;
    logic [COUNT_W-1:0] load_value;
    logic               refill;
    logic [COUNT_W-1:0] refill_value;
    logic               commit;
  } cell_ctrl_t;

  // Remaining amount travelling down the chain, largest slot first.
  typedef struct packed {
    logic                valid;
    logic [AMOUNT_W-1:0] rest;
  } token_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cdp_cell.sv
// ============================================================================
// cdp_cell: one denomination slot of the change chain
// Holds the coin count of its slot. A token carrying the unpaid rest enters,
// the cell takes as many of its coins as fit and passes the new rest on.
// ============================================================================
`default_nettype none

module cdp_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [cdp_pkg::SLOT_W-1:0]   cell_id,
  input  cdp_pkg::cell_ctrl_t          ctrl,
  input  cdp_pkg::token_t              tok_in,
  output cdp_pkg::token_t              tok_out,
  output logic [cdp_pkg::COUNT_W-1:0]  take,
  output logic                         nonzero
);
  import cdp_pkg::*;

  logic [COUNT_W-1:0]          count_r;
  logic                        busy_r;
  logic [AMOUNT_W-1:0]         quot_r;
  logic [AMOUNT_W-1:0]         rest_r;
  logic [COUNT_W-1:0]          take_r;
  logic                        tok_vld_r;
  logic [AMOUNT_W-1:0]         tok_rest_r;

  logic [VALUE_W-1:0]          face;
  logic [AMOUNT_W+RECIP_W-1:0] prod;
  logic [COUNT_W-1:0]          take_nxt;
  logic [COUNT_W+VALUE_W-1:0]  paid;
  logic [AMOUNT_W-1:0]         rest_nxt;

  assign face = FACE_TAB[cell_id];
  assign prod = (AMOUNT_W+RECIP_W)'(tok_in.rest) * (AMOUNT_W+RECIP_W)'(RECIP_TAB[cell_id]);

  // After the quotient register: bound the quotient by the stock, then pay it off.
  always_comb begin
    if (quot_r > AMOUNT_W'(count_r)) begin
      take_nxt = count_r;
    end else begin
      take_nxt = quot_r[COUNT_W-1:0];
    end
    paid     = (COUNT_W+VALUE_W)'(take_nxt) * (COUNT_W+VALUE_W)'(face);
    rest_nxt = rest_r - paid[AMOUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      busy_r    <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      busy_r    <= tok_in.valid;
      tok_vld_r <= busy_r;
      if (ctrl.refill) begin
        count_r <= ctrl.refill_value;
      end else if (ctrl.load_we && ctrl.load_slot == cell_id) begin
        count_r <= ctrl.load_value;
      end else if (ctrl.commit) begin
        count_r <= count_r - take_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      quot_r <= prod[AMOUNT_W+RECIP_W-1:RECIP_W];
      rest_r <= tok_in.rest;
    end
    if (busy_r) begin
      take_r     <= take_nxt;
      tok_rest_r <= rest_nxt;
    end
  end

  assign tok_out.valid = tok_vld_r;
  assign tok_out.rest  = tok_rest_r;
  assign take          = take_r;
  assign nonzero       = (count_r != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/coin_change_dispenser.sv
// ============================================================================
// coin_change_dispenser: greedy change maker with a coin inventory
// Keeps a coin count for each of eight denominations and pays change from
// the largest coin down, bounded by the stock, debiting only on success.
// ============================================================================
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one word per
//   operation: load one slot count, refill all slots from the default count,
//   or make change for an amount. Load and refill produce no result word and
//   complete in the cycle they are accepted. A change word produces one or
//   more result words on out_valid/out_ready/out_data, the final one marked
//   with last. The cfg_we/cfg_wdata port sets the default count for refill.
//   Flow: a change request walks a token down a chain of eight slot cells
//   before the first result word is presented.
//   Results are then emitted one per cycle while the receiver is ready,
//   except that each unused slot is passed over before the next result;
//   no new word is accepted until the change is complete. An empty
//   inventory is answered without the chain: its result word passes
//   through the response state into the output register.
//   Reset clears every count to zero and the default count to 20.
//   While the receiver stalls, the result waits in the output register and
//   the emission pauses; no result is ever dropped.
// ============================================================================
`default_nettype none

module coin_change_dispenser (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  cdp_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output cdp_pkg::out_word_t          out_data,
  input  wire                         cfg_we,
  input  wire  [cdp_pkg::COUNT_W-1:0] cfg_wdata
);
  import cdp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_RESP,
    S_EMIT
  } state_t;

  state_t                state_r;
  logic [COUNT_W-1:0]    default_count_r;
  logic [STATUS_W-1:0]   status_r;
  logic [SLOT_W-1:0]     idx_r;
  logic                  out_valid_r;
  out_word_t             out_data_r;

  cell_ctrl_t            ctrl;
  token_t                tok [NUM_DENOMS+1];
  logic [COUNT_W-1:0]    take_arr [NUM_DENOMS];
  logic [NUM_DENOMS-1:0] nz;
  logic [NUM_DENOMS-1:0] take_nz;

  logic                  accept;
  logic                  out_free;
  logic                  emit;
  logic                  any_stock;
  logic                  lower_nz;
  logic [COUNT_W-1:0]    cur_take;

  // The chain of slot cells: the token enters at the largest coin and
  // leaves after the smallest one.
  for (genvar i = 0; i < NUM_DENOMS; i++) begin : g_cell
    cdp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (SLOT_W'(i)),
      .ctrl    (ctrl),
      .tok_in  (tok[i+1]),
      .tok_out (tok[i]),
      .take    (take_arr[i]),
      .nonzero (nz[i])
    );
    assign take_nz[i] = (take_arr[i] != '0);
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign any_stock = |nz;
  assign cur_take  = take_arr[idx_r];

  // A new result word is loaded into the output register this cycle.
  assign emit = out_free &&
                ((state_r == S_RESP) || ((state_r == S_EMIT) && (cur_take != '0)));

  // The current result is the last one when no smaller slot pays anything.
  always_comb begin
    lower_nz = 1'b0;
    for (int i = 0; i < NUM_DENOMS; i++) begin
      if (SLOT_W'(i) < idx_r && take_nz[i]) begin
        lower_nz = 1'b1;
      end
    end
  end

  always_comb begin
    ctrl.load_we      = accept && (in_data.op == OP_LOAD);
    ctrl.load_slot    = in_data.slot;
    ctrl.load_value   = in_data.count_value;
    ctrl.refill       = accept && (in_data.op == OP_REFILL);
    ctrl.refill_value = default_count_r;
    // Commit only once the chain has paid the whole amount.
    ctrl.commit       = (state_r == S_RUN) && tok[0].valid &&
                        (tok[0].rest == '0) && (take_nz != '0);
    tok[NUM_DENOMS].valid = accept && (in_data.op == OP_CHANGE) && any_stock;
    tok[NUM_DENOMS].rest  = in_data.amount;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      default_count_r <= DEFAULT_COUNT_RST;
      out_valid_r     <= 1'b0;
      status_r        <= ST_OK;
      idx_r           <= '0;
    end else begin
      if (cfg_we) begin
        default_count_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_data.op == OP_CHANGE) begin
            if (any_stock) begin
              state_r <= S_RUN;
            end else begin
              status_r <= ST_EMPTY;
              state_r  <= S_RESP;
            end
          end
        end
        S_RUN: begin
          if (tok[0].valid) begin
            if (tok[0].rest != '0) begin
              status_r <= ST_NO_EXACT;
              state_r  <= S_RESP;
            end else if (take_nz == '0) begin
              status_r <= ST_OK;
              state_r  <= S_RESP;
            end else begin
              idx_r   <= SLOT_W'(NUM_DENOMS - 1);
              state_r <= S_EMIT;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_data_r.status     <= status_r;
            out_data_r.coin_slot  <= '0;
            out_data_r.face_cents <= '0;
            out_data_r.dispensed  <= '0;
            out_data_r.last       <= 1'b1;
            state_r               <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (cur_take == '0) begin
            idx_r <= idx_r - 1'b1;
          end else if (out_free) begin
            out_data_r.status     <= ST_OK;
            out_data_r.coin_slot  <= idx_r;
            out_data_r.face_cents <= FACE_TAB[idx_r];
            out_data_r.dispensed  <= cur_take;
            out_data_r.last       <= !lower_nz;
            if (lower_nz) begin
              idx_r <= idx_r - 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
